[src/vbd_pkg.sv]
// Shared constants and types for the vertical blend deinterlacer.
package vbd_pkg;

    localparam int LINE_WORDS  = 1024;
    localparam int ADDR_W      = $clog2(LINE_WORDS);
    localparam int WIDTH_W     = 11;
    localparam int HEIGHT_W    = 16;
    localparam int PIX_W       = 8;
    localparam int WORD_W      = 4 * PIX_W;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W  = FIFO_PTR_W + 1;

    typedef logic [CFG_IDX_W-1:0] cfg_index_t;

    localparam cfg_index_t REG_WIDTH_WORDS = cfg_index_t'(0);
    localparam cfg_index_t REG_HEIGHT      = cfg_index_t'(1);

    // One queued input item: up to two result words and their flags
    typedef struct packed {
        logic [WORD_W-1:0] word0;
        logic [WORD_W-1:0] word1;
        logic              has_first;
        logic              has_second;
        logic              row_last;
    } result_entry_t;

endpackage

[src/vertical_blend_deinterlace_core.sv]
// Top level of the vertical 1-2-1 blend deinterlacer.
//
// Input: one 8-bit plane in raster order, four pixels (pix0..pix3) per transfer
// on the in_valid/in_ready channel. Output: filtered words (out0..out3) with
// row_end, frame_end and last flags on the out_valid/out_ready channel.
// Configuration: cfg_valid/cfg_ready write with cfg_index (0 width_words, 1 height)
// and cfg_data; cfg_ready is always high. A known-index write restarts the frame.
// The first input row produces nothing; each later word produces the matching
// word of the previous output row, and a word of the last row also produces the
// final row word as a second transfer.
// Throughput: one input word per cycle while in_ready is high; a last-row word
// leaves as two transfers through the single output register.
// A four-entry result queue separates the line-memory pipeline from the output
// stage; when the receiver stalls the queue fills and in_ready drops.
// Reset: width_words 1, height 2, counters zero, queue empty; the line memory
// is not cleared; every read whose data is used hits a word written earlier in the same frame.
module vertical_blend_deinterlace_core
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [vbd_pkg::PIX_W-1:0]           pix0,
    input  logic [vbd_pkg::PIX_W-1:0]           pix1,
    input  logic [vbd_pkg::PIX_W-1:0]           pix2,
    input  logic [vbd_pkg::PIX_W-1:0]           pix3,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [vbd_pkg::PIX_W-1:0]           out0,
    output logic [vbd_pkg::PIX_W-1:0]           out1,
    output logic [vbd_pkg::PIX_W-1:0]           out2,
    output logic [vbd_pkg::PIX_W-1:0]           out3,
    output logic                                row_end,
    output logic                                frame_end,
    output logic                                last,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  vbd_pkg::cfg_index_t                 cfg_index,
    input  logic [vbd_pkg::CFG_DATA_W-1:0]      cfg_data
);

    logic                             push;
    vbd_pkg::result_entry_t           push_entry;
    logic                             pop;
    vbd_pkg::result_entry_t           head_entry;
    logic                             head_valid;
    logic [vbd_pkg::FIFO_CNT_W-1:0]   fifo_count;
    logic [vbd_pkg::WORD_W-1:0]       out_word;

    assign cfg_ready = 1'b1;

    vbd_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_word    ({pix3, pix2, pix1, pix0}),
        .cfg_we     (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fifo_count (fifo_count),
        .push       (push),
        .push_entry (push_entry)
    );

    vbd_fifo u_fifo
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head_entry (head_entry),
        .head_valid (head_valid),
        .count      (fifo_count)
    );

    vbd_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_entry (head_entry),
        .head_valid (head_valid),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_word   (out_word),
        .row_end    (row_end),
        .frame_end  (frame_end),
        .last       (last)
    );

    assign out0 = out_word[0*vbd_pkg::PIX_W +: vbd_pkg::PIX_W];
    assign out1 = out_word[1*vbd_pkg::PIX_W +: vbd_pkg::PIX_W];
    assign out2 = out_word[2*vbd_pkg::PIX_W +: vbd_pkg::PIX_W];
    assign out3 = out_word[3*vbd_pkg::PIX_W +: vbd_pkg::PIX_W];

endmodule

[src/vbd_front.sv]
// Front end: register file, raster counters, line memory and filter arithmetic.
module vbd_front
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [vbd_pkg::WORD_W-1:0]           in_word,
    input  logic                                 cfg_we,
    input  vbd_pkg::cfg_index_t                  cfg_index,
    input  logic [vbd_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic [vbd_pkg::FIFO_CNT_W-1:0]       fifo_count,
    output logic                                 push,
    output vbd_pkg::result_entry_t               push_entry
);

    logic [vbd_pkg::WIDTH_W-1:0]  width_reg;
    logic [vbd_pkg::WIDTH_W-1:0]  width_next;
    logic [vbd_pkg::HEIGHT_W-1:0] height_reg;
    logic [vbd_pkg::HEIGHT_W-1:0] height_next;
    logic [vbd_pkg::ADDR_W-1:0]   col_reg;
    logic [vbd_pkg::ADDR_W-1:0]   col_next;
    logic [vbd_pkg::HEIGHT_W-1:0] row_reg;
    logic [vbd_pkg::HEIGHT_W-1:0] row_next;

    logic [vbd_pkg::WIDTH_W-1:0]  eff_w;
    logic [vbd_pkg::HEIGHT_W-1:0] eff_h;
    logic                         accept;
    logic                         row_last;
    logic                         frame_last;

    logic                         s1_valid_reg;
    logic [vbd_pkg::ADDR_W-1:0]   s1_col_reg;
    logic [vbd_pkg::WORD_W-1:0]   s1_cur_reg;
    logic                         s1_first_reg;
    logic                         s1_blend_reg;
    logic                         s1_frame_last_reg;
    logic                         s1_row_last_reg;

    logic [2*vbd_pkg::WORD_W-1:0] line_mem [vbd_pkg::LINE_WORDS];
    logic [2*vbd_pkg::WORD_W-1:0] rd_data_reg;
    logic [2*vbd_pkg::WORD_W-1:0] fwd_data_reg;
    logic                         fwd_reg;
    logic                         fwd_next;

    logic [vbd_pkg::WORD_W-1:0]   above;
    logic [vbd_pkg::WORD_W-1:0]   center;
    logic [2*vbd_pkg::WORD_W-1:0] wr_data;

    function automatic logic [vbd_pkg::WORD_W-1:0] avg_up
    (
        input logic [vbd_pkg::WORD_W-1:0] x,
        input logic [vbd_pkg::WORD_W-1:0] y
    );
        logic [vbd_pkg::WORD_W-1:0] r;
        logic [vbd_pkg::PIX_W:0]    s;
        r = '0;
        for (int k = 0; k < 4; k++)
        begin
            s = {1'b0, x[k*vbd_pkg::PIX_W +: vbd_pkg::PIX_W]}
              + {1'b0, y[k*vbd_pkg::PIX_W +: vbd_pkg::PIX_W]} + 9'd1;
            r[k*vbd_pkg::PIX_W +: vbd_pkg::PIX_W] = s[vbd_pkg::PIX_W:1];
        end
        return r;
    endfunction

    function automatic logic [vbd_pkg::WORD_W-1:0] blend3
    (
        input logic [vbd_pkg::WORD_W-1:0] a,
        input logic [vbd_pkg::WORD_W-1:0] b,
        input logic [vbd_pkg::WORD_W-1:0] c
    );
        logic [vbd_pkg::WORD_W-1:0] r;
        logic [vbd_pkg::PIX_W+1:0]  s;
        r = '0;
        for (int k = 0; k < 4; k++)
        begin
            s = {2'b00, a[k*vbd_pkg::PIX_W +: vbd_pkg::PIX_W]}
              + {1'b0, b[k*vbd_pkg::PIX_W +: vbd_pkg::PIX_W], 1'b0}
              + {2'b00, c[k*vbd_pkg::PIX_W +: vbd_pkg::PIX_W]} + 10'd2;
            r[k*vbd_pkg::PIX_W +: vbd_pkg::PIX_W] = s[vbd_pkg::PIX_W+1:2];
        end
        return r;
    endfunction

    // Clamp register values to the legal frame geometry
    always_comb
    begin
        if (width_reg == '0)
            eff_w = vbd_pkg::WIDTH_W'(1);
        else if (width_reg > vbd_pkg::WIDTH_W'(vbd_pkg::LINE_WORDS))
            eff_w = vbd_pkg::WIDTH_W'(vbd_pkg::LINE_WORDS);
        else
            eff_w = width_reg;
        eff_h = (height_reg < vbd_pkg::HEIGHT_W'(2)) ? vbd_pkg::HEIGHT_W'(2) : height_reg;
    end

    assign in_ready = ({1'b0, fifo_count} + {{vbd_pkg::FIFO_CNT_W{1'b0}}, s1_valid_reg})
                      < (vbd_pkg::FIFO_CNT_W + 1)'(vbd_pkg::FIFO_DEPTH);
    assign accept     = in_valid && in_ready;
    assign row_last   = ({1'b0, col_reg} + vbd_pkg::WIDTH_W'(1)) >= eff_w;
    assign frame_last = ({1'b0, row_reg} + (vbd_pkg::HEIGHT_W + 1)'(1)) >= {1'b0, eff_h};

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        if (cfg_we)
        begin
            // A known index starts a new frame; an unknown index changes nothing
            unique case (cfg_index)
                vbd_pkg::REG_WIDTH_WORDS:
                begin
                    width_next = cfg_data[vbd_pkg::WIDTH_W-1:0];
                    col_next   = '0;
                    row_next   = '0;
                end
                vbd_pkg::REG_HEIGHT:
                begin
                    height_next = cfg_data[vbd_pkg::HEIGHT_W-1:0];
                    col_next    = '0;
                    row_next    = '0;
                end
                default:
                begin
                    width_next = width_reg;
                end
            endcase
        end
        else if (accept)
        begin
            if (row_last)
            begin
                col_next = '0;
                row_next = frame_last ? '0 : row_reg + vbd_pkg::HEIGHT_W'(1);
            end
            else
            begin
                col_next = col_reg + vbd_pkg::ADDR_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= vbd_pkg::WIDTH_W'(1);
            height_reg   <= vbd_pkg::HEIGHT_W'(2);
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
            fwd_reg      <= 1'b0;
        end
        else
        begin
            width_reg    <= width_next;
            height_reg   <= height_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            s1_valid_reg <= accept;
            fwd_reg      <= fwd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_col_reg        <= col_reg;
            s1_cur_reg        <= in_word;
            s1_first_reg      <= (row_reg != '0);
            s1_blend_reg      <= (row_reg >= vbd_pkg::HEIGHT_W'(2));
            s1_frame_last_reg <= frame_last;
            s1_row_last_reg   <= row_last;
        end
        if (s1_valid_reg)
        begin
            fwd_data_reg <= wr_data;
        end
    end

    // Line memory holds {row r-2, row r-1} per word column
    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            line_mem[s1_col_reg] <= wr_data;
        end
        rd_data_reg <= line_mem[col_reg];
    end

    // Forward the word written in the accept cycle when the same column is read
    assign fwd_next = accept && s1_valid_reg && (s1_col_reg == col_reg);

    assign above   = fwd_reg ? fwd_data_reg[2*vbd_pkg::WORD_W-1:vbd_pkg::WORD_W]
                             : rd_data_reg[2*vbd_pkg::WORD_W-1:vbd_pkg::WORD_W];
    assign center  = fwd_reg ? fwd_data_reg[vbd_pkg::WORD_W-1:0]
                             : rd_data_reg[vbd_pkg::WORD_W-1:0];
    assign wr_data = {center, s1_cur_reg};

    always_comb
    begin
        push_entry.word0      = s1_blend_reg ? blend3(above, center, s1_cur_reg)
                                             : avg_up(center, s1_cur_reg);
        push_entry.word1      = avg_up(center, s1_cur_reg);
        push_entry.has_first  = s1_first_reg;
        push_entry.has_second = s1_frame_last_reg;
        push_entry.row_last   = s1_row_last_reg;
        push                  = s1_valid_reg && (s1_first_reg || s1_frame_last_reg);
    end

    a_col_in_row: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, col_reg} < eff_w))
        else $error("column counter past row width");

    a_fwd_follows_pair: assert property (@(posedge clk) disable iff (!rst_n)
        fwd_reg |-> s1_valid_reg && $past(s1_valid_reg))
        else $error("forwarding without back-to-back items");

endmodule

[src/vbd_fifo.sv]
// Short result queue between the front end and the output stage.
module vbd_fifo
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    input  vbd_pkg::result_entry_t            push_entry,
    input  logic                              pop,
    output vbd_pkg::result_entry_t            head_entry,
    output logic                              head_valid,
    output logic [vbd_pkg::FIFO_CNT_W-1:0]    count
);

    vbd_pkg::result_entry_t            fifo_mem [vbd_pkg::FIFO_DEPTH];
    logic [vbd_pkg::FIFO_PTR_W-1:0]    wr_ptr_reg;
    logic [vbd_pkg::FIFO_PTR_W-1:0]    wr_ptr_next;
    logic [vbd_pkg::FIFO_PTR_W-1:0]    rd_ptr_reg;
    logic [vbd_pkg::FIFO_PTR_W-1:0]    rd_ptr_next;
    logic [vbd_pkg::FIFO_CNT_W-1:0]    count_reg;
    logic [vbd_pkg::FIFO_CNT_W-1:0]    count_next;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + vbd_pkg::FIFO_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + vbd_pkg::FIFO_PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg
                    + vbd_pkg::FIFO_CNT_W'(push)
                    - vbd_pkg::FIFO_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_mem[wr_ptr_reg] <= push_entry;
        end
    end

    assign head_entry = fifo_mem[rd_ptr_reg];
    assign head_valid = (count_reg != '0);
    assign count      = count_reg;

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg < vbd_pkg::FIFO_CNT_W'(vbd_pkg::FIFO_DEPTH)) || pop)
        else $error("result queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("result queue underflow");

endmodule

[src/vbd_back.sv]
// Output stage: splits each queued entry into one or two result transfers.
module vbd_back
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  vbd_pkg::result_entry_t            head_entry,
    input  logic                              head_valid,
    output logic                              pop,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [vbd_pkg::WORD_W-1:0]        out_word,
    output logic                              row_end,
    output logic                              frame_end,
    output logic                              last
);

    logic                         phase_reg;
    logic                         phase_next;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic [vbd_pkg::WORD_W-1:0]   word_reg;
    logic                         row_end_reg;
    logic                         frame_end_reg;
    logic                         last_reg;

    logic                         emit;
    logic                         take_first;
    logic                         is_last;

    assign emit       = head_valid && (!out_valid_reg || out_ready);
    assign take_first = head_entry.has_first && !phase_reg;
    assign is_last    = take_first ? !head_entry.has_second : 1'b1;
    assign pop        = emit && is_last;

    always_comb
    begin
        phase_next     = phase_reg;
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            phase_next     = !is_last;
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            word_reg      <= take_first ? head_entry.word0 : head_entry.word1;
            row_end_reg   <= head_entry.row_last;
            frame_end_reg <= take_first ? 1'b0 : head_entry.row_last;
            last_reg      <= is_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = word_reg;
    assign row_end   = row_end_reg;
    assign frame_end = frame_end_reg;
    assign last      = last_reg;

    a_entry_has_result: assert property (@(posedge clk) disable iff (!rst_n)
        head_valid |-> (head_entry.has_first || head_entry.has_second))
        else $error("queued entry carries no result");

    a_phase_on_pair: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg |-> head_valid && head_entry.has_first && head_entry.has_second)
        else $error("second half pending without a two-result entry");

endmodule
